@@ rtl/okc_pkg.sv @@
// Package for the ordered key set: codes, payload structs, control types.
package okc_pkg;

    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 5;
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_KEY_BITS = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
    } okc_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   popped_key;
        logic [COUNT_W-1:0] entry_count;
    } okc_rsp_t;

    typedef struct packed {
        logic match;
        logic ins;
        logic rem;
    } okc_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } okc_state_t;

endpackage

@@ rtl/okc_cell.sv @@
// One slot of the key row: holds a key, compares it and shifts to either neighbor.
module okc_cell
    import okc_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  okc_ctrl_t           ctrl,
    input  logic [KEY_BITS-1:0] search_key,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic                left_valid,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic                right_valid,
    input  logic                seen_in,
    output logic [KEY_BITS-1:0] key,
    output logic                valid,
    output logic                hit,
    output logic                seen_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                valid_reg;
    logic                valid_next;
    logic                hit_reg;
    logic                hit_next;

    assign seen_out = seen_in | hit_reg;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (ctrl.match)
        begin
            hit_next = valid_reg && (key_reg == search_key);
        end
        if (ctrl.ins)
        begin
            key_next   = left_key;
            valid_next = left_valid;
        end
        else if (ctrl.rem && seen_out)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

@@ rtl/ordered_key_set_core.sv @@
// Ordered key set: a row of key cells, newest at the front, under a small sequencer.
// Sequence: an accepted start enters S_MATCH, then S_APPLY; the result strobe done is
// registered out of S_APPLY, and busy is high while in S_MATCH and S_APPLY.
// Each transaction runs a compare pass over all cells, one shift pass through the row,
// then the result; a new start is taken only once busy is low. The receiver cannot stall.
// Reset: the set is empty and no result is pending; no clearing pass is run.
module ordered_key_set_core
    import okc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  okc_req_t req,
    output logic     done,
    output okc_rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    okc_state_t          state_reg;
    okc_state_t          state_next;
    okc_req_t            op_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic                done_reg;
    logic                done_next;
    okc_rsp_t            rsp_reg;
    okc_rsp_t            rsp_next;

    okc_ctrl_t           ctrl;
    logic                pop_front;
    logic [KEY_BITS-1:0] search_key;
    logic [KEY_BITS-1:0] key_w   [CAPACITY];
    logic                valid_w [CAPACITY];
    logic [CAPACITY-1:0] hit_w;
    logic                seen_w  [CAPACITY+1];
    logic                any_hit;
    logic                is_full;
    logic                is_empty;

    assign search_key = KEY_BITS'(op_reg.key);
    assign seen_w[0]  = pop_front;
    assign any_hit    = |hit_w;
    assign is_full    = (fill_reg == CNT_W'(CAPACITY));
    assign is_empty   = (fill_reg == '0);

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [KEY_BITS-1:0] lk;
            logic                lv;
            logic [KEY_BITS-1:0] rk;
            logic                rv;

            if (i == 0)
            begin : g_front
                assign lk = search_key;
                assign lv = 1'b1;
            end
            else
            begin : g_mid
                assign lk = key_w[i-1];
                assign lv = valid_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_back
                assign rk = key_w[i];
                assign rv = 1'b0;
            end
            else
            begin : g_inner
                assign rk = key_w[i+1];
                assign rv = valid_w[i+1];
            end

            okc_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .search_key  (search_key),
                .left_key    (lk),
                .left_valid  (lv),
                .right_key   (rk),
                .right_valid (rv),
                .seen_in     (seen_w[i]),
                .key         (key_w[i]),
                .valid       (valid_w[i]),
                .hit         (hit_w[i]),
                .seen_out    (seen_w[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl                 = '0;
        pop_front            = 1'b0;
        fill_next            = fill_reg;
        done_next            = 1'b0;
        rsp_next             = rsp_reg;
        ctrl.match           = (state_reg == S_MATCH);
        if (state_reg == S_APPLY)
        begin
            done_next           = 1'b1;
            rsp_next.status     = ST_OK;
            rsp_next.popped_key = '0;
            case (op_reg.cmd)
                CMD_INSERT:
                begin
                    if (any_hit)
                    begin
                        rsp_next.status = ST_DUP;
                    end
                    else if (is_full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins  = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    if (any_hit)
                    begin
                        ctrl.rem  = 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = ST_MISS;
                    end
                end
                CMD_POP:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = ST_MISS;
                    end
                    else
                    begin
                        ctrl.rem            = 1'b1;
                        pop_front           = 1'b1;
                        rsp_next.popped_key = KEY_W'(key_w[0]);
                        fill_next           = fill_reg - 1'b1;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
            rsp_next.entry_count = COUNT_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (start && !busy)
        begin
            op_reg <= req;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
